// ===== rtl/core/dma_pkg.sv =====
package dma_pkg;

    localparam int unsigned POS_W = 24;
    localparam int unsigned SUM_W = 64;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned LEN_W = 7;
    localparam int unsigned OUT_TDATA_W = 208;
    localparam int unsigned IN_TDATA_W  = 48;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic signed [SUM_W-1:0] M25 = 64'sd16777215;
    localparam logic signed [SUM_W-1:0] M48 = 64'sd281474943156225;

    typedef struct packed {
        logic                    action;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    start;
    } t_cmd;

    typedef struct packed {
        logic [5:0]        step_index;
        logic [24:0]       mean_x;
        logic [24:0]       mean_y;
        logic [47:0]       mean_x2;
        logic [47:0]       mean_y2;
        logic [48:0]       mean_xy;
        logic              last_entry;
    } t_result;

endpackage

// ===== rtl/core/displacement_moment_accumulator_core.sv =====
// Each point passes through the back end's states in order (accept, multiply, read,
// add, write), and the next point is taken only once it is done; the two-word front
// queue absorbs a short burst while the back end works.
// A fetch emits one word per step in use; with a non-zero count each word passes
// its five sums through the bit-serial divider, plus read, format and send; with a
// zero count it only reads, formats and sends; any receiver stall adds to this.
// Reset (synchronous, active low) clears control state at once, then zeroes the
// table in a pass over all MAX_STEPS rows; a fetch that clears the table repeats the pass.
module displacement_moment_accumulator_core #(
    parameter int MAX_STEPS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [dma_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // pos_x[23:0], pos_y[47:24]
    input  logic [1:0]   s_axis_tuser,   // action[0], trajectory_start[1]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // step_index, mean_x, mean_y, mean_x2, mean_y2, mean_xy, zero pad
    output logic [dma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_entry
);
    import dma_pkg::*;

    logic [LEN_W-1:0] r_len;
    t_cmd    w_in, w_q;
    logic    w_qv, w_qr;
    t_result w_res;

    // hold the length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= 7'd64;
        else if (i_cfg_we) r_len <= i_cfg_wdata;
    end

    always_comb begin
        w_in.action = s_axis_tuser[0];
        w_in.start  = s_axis_tuser[1];
        w_in.pos_x  = s_axis_tdata[23:0];
        w_in.pos_y  = s_axis_tdata[47:24];
    end

    dma_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    dma_engine #(.MAX_STEPS(MAX_STEPS)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_len(r_len),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.mean_xy, w_res.mean_y2, w_res.mean_x2,
                           w_res.mean_y, w_res.mean_x, w_res.step_index};
    assign m_axis_tlast = w_res.last_entry;

    // a stalled result word must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    // pad bits above mean_xy stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[207:201] == 7'd0))
        else $error("result pad bits not zero");
endmodule

// ===== rtl/core/dma_queue.sv =====
module dma_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dma_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output dma_pkg::t_cmd o_cmd
);
    import dma_pkg::*;

    // two-entry skid queue
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end
endmodule

// ===== rtl/core/dma_div.sv =====
module dma_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [63:0]     i_num,
    input  logic [31:0]            i_den,
    output logic                   o_done,
    output logic signed [63:0]     o_quo
);
    import dma_pkg::*;

    // restoring divide on magnitude, one bit per cycle
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_rem;
    logic [32:0] n_try;

    always_comb begin
        n_rem = {r_rem[31:0], r_q[63]};
        n_try = n_rem - {1'b0, i_den};
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (i_start) begin
            r_neg  <= i_num[63];
            r_q    <= i_num[63] ? (64'd0 - 64'(i_num)) : 64'(i_num);
            r_rem  <= '0;
            r_cnt  <= 7'd0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (!n_try[32]) begin
                r_rem <= n_try;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_q   <= {r_q[62:0], 1'b0};
            end
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end
    end
endmodule

// ===== rtl/core/dma_engine.sv =====
module dma_engine #(
    parameter int MAX_STEPS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dma_pkg::LEN_W-1:0]    i_len,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  dma_pkg::t_cmd                i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output dma_pkg::t_result             o_res
);
    import dma_pkg::*;

    localparam int AW = $clog2(MAX_STEPS);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_ADD = 4'd2, S_WR = 4'd3,
                           S_CLR = 4'd4, S_FRD = 4'd5, S_FDIV = 4'd6, S_FWAIT = 4'd7,
                           S_FOUT = 4'd8, S_MUL = 4'd9, S_ZERO = 4'd10;

    logic [SUM_W-1:0] r_mem [5][MAX_STEPS];
    logic [SUM_W-1:0] r_rd [5];
    logic [3:0]       r_st;
    logic signed [POS_W-1:0] r_ox, r_oy;
    logic [AW:0]      r_pidx;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_row;
    logic [AW:0]      r_k;
    logic signed [POS_W:0] r_dx, r_dy;
    logic signed [SUM_W-1:0] r_add [5];
    logic [SUM_W-1:0] r_res [5];
    logic [2:0]       r_f;
    logic [AW:0]      w_len_e;
    logic             r_dstart;
    logic             d_done;
    logic signed [SUM_W-1:0] d_quo;
    logic signed [SUM_W-1:0] w_num;
    t_result          r_out;

    function automatic logic [SUM_W-1:0] f_sat(input logic signed [SUM_W-1:0] a,
                                               input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if (!a[SUM_W-1] && !b[SUM_W-1] && s[SUM_W-1]) return {1'b0, {(SUM_W-1){1'b1}}};
        if (a[SUM_W-1] && b[SUM_W-1] && !s[SUM_W-1]) return {1'b1, {(SUM_W-1){1'b0}}};
        return s;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_clamp(input logic signed [SUM_W-1:0] v,
                                                        input logic signed [SUM_W-1:0] lo,
                                                        input logic signed [SUM_W-1:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    always_comb begin
        if (i_len == '0) w_len_e = (AW+1)'(1);
        else if (int'(i_len) > MAX_STEPS) w_len_e = (AW+1)'(MAX_STEPS);
        else w_len_e = (AW+1)'(i_len);
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_FOUT);
    assign o_res   = r_out;
    assign w_num   = $signed(r_res[r_f]);

    dma_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(w_num), .i_den(r_cnt), .o_done(d_done), .o_quo(d_quo)
    );

    always_ff @(posedge i_clk) begin
        r_dstart <= 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd.action == ACT_ADD) begin
                        if (i_cmd.start) begin
                            r_ox   <= i_cmd.pos_x;
                            r_oy   <= i_cmd.pos_y;
                            r_pidx <= '0;
                            if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                            r_dx <= '0;
                            r_dy <= '0;
                            r_row <= '0;
                            r_st <= S_MUL;
                        end else if (r_pidx < w_len_e) begin
                            r_dx  <= (POS_W+1)'(i_cmd.pos_x) - (POS_W+1)'(r_ox);
                            r_dy  <= (POS_W+1)'(i_cmd.pos_y) - (POS_W+1)'(r_oy);
                            r_row <= r_pidx[AW-1:0];
                            r_st  <= S_MUL;
                        end
                    end else begin
                        r_k  <= '0;
                        r_st <= S_FRD;
                    end
                end
            end
            S_MUL: begin
                r_add[0] <= SUM_W'(r_dx);
                r_add[1] <= SUM_W'(r_dy);
                r_add[2] <= SUM_W'(r_dx * r_dx);
                r_add[3] <= SUM_W'(r_dy * r_dy);
                r_add[4] <= SUM_W'(r_dx * r_dy);
                r_st <= S_RD;
            end
            S_RD: begin
                for (int i = 0; i < 5; i++)
                    r_rd[i] <= r_mem[i][r_row];
                r_st <= S_ADD;
            end
            S_ADD: begin
                for (int i = 0; i < 5; i++)
                    r_res[i] <= f_sat(r_rd[i], r_add[i]);
                r_st <= S_WR;
            end
            S_WR: begin
                for (int i = 0; i < 5; i++)
                    r_mem[i][r_row] <= r_res[i];
                r_pidx <= r_pidx + 1'b1;
                r_st <= S_IDLE;
            end
            S_FRD: begin
                for (int i = 0; i < 5; i++)
                    r_res[i] <= r_mem[i][r_k[AW-1:0]];
                r_f <= 3'd0;
                r_st <= S_FDIV;
            end
            S_FDIV: begin
                if (r_cnt == '0) begin
                    r_st <= S_CLR;
                end else begin
                    r_dstart <= 1'b1;
                    r_st <= S_FWAIT;
                end
            end
            S_FWAIT: begin
                if (d_done) begin
                    r_res[r_f] <= d_quo;
                    if (r_f == 3'd4) r_st <= S_CLR;
                    else begin
                        r_f <= r_f + 3'd1;
                        r_st <= S_FDIV;
                    end
                end
            end
            S_CLR: begin
                r_out.step_index <= 6'(r_k);
                r_out.mean_x  <= 25'(f_clamp($signed(r_res[0]), -M25, M25));
                r_out.mean_y  <= 25'(f_clamp($signed(r_res[1]), -M25, M25));
                r_out.mean_x2 <= 48'(f_clamp($signed(r_res[2]), '0, M48));
                r_out.mean_y2 <= 48'(f_clamp($signed(r_res[3]), '0, M48));
                r_out.mean_xy <= 49'(f_clamp($signed(r_res[4]), -M48, M48));
                r_out.last_entry <= (r_k + 1'b1 == w_len_e);
                r_st <= S_FOUT;
            end
            S_FOUT: begin
                if (i_ready) begin
                    if (r_k + 1'b1 == w_len_e) begin
                        if (r_cnt != '0) begin
                            r_cnt <= '0;
                            r_row <= '0;
                            r_st  <= S_ZERO;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end else begin
                        r_k  <= r_k + 1'b1;
                        r_st <= S_FRD;
                    end
                end
            end
            S_ZERO: begin
                // zero one row per cycle across the whole table
                for (int i = 0; i < 5; i++)
                    r_mem[i][r_row] <= '0;
                r_row <= r_row + 1'b1;
                if (r_row == AW'(MAX_STEPS-1)) r_st <= S_IDLE;
            end
            default: r_st <= S_IDLE;
        endcase
        if (!i_rst_n) begin
            r_st <= S_ZERO;
            r_row <= '0;
            r_cnt <= '0;
            r_pidx <= '0;
            r_ox <= '0;
            r_oy <= '0;
            r_dstart <= 1'b0;
        end
    end
endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dma_pkg::*;

    localparam int STEPS      = 64;
    localparam int IDLE_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int SETTLE     = 200;    // drain time for points still in the back end
    localparam int HOLD_OFF   = 600;    // long receiver stall for the pressure phase

    // Scoreboard: keeps its own copy of the moment table and predicts every
    // word of a fetch at the moment the fetch is accepted.
    class moment_scoreboard;
        longint      acc_x[STEPS];
        longint      acc_y[STEPS];
        longint      acc_x2[STEPS];
        longint      acc_y2[STEPS];
        longint      acc_xy[STEPS];
        int          org_x;
        int          org_y;
        int unsigned cursor;
        int unsigned traj_count;
        logic [6:0]  len_reg;
        t_result     expected_words[$];
        int          errors;
        int          words_checked;
        int          points_seen;
        int          fetches_seen;

        function void reset_state();
            for (int k = 0; k < STEPS; k++) begin
                acc_x[k] = 0; acc_y[k] = 0; acc_x2[k] = 0; acc_y2[k] = 0; acc_xy[k] = 0;
            end
            org_x = 0;
            org_y = 0;
            cursor = 0;
            traj_count = 0;
            len_reg = 7'd64;
            errors = 0;
        endfunction

        function void set_length(logic [6:0] v);
            len_reg = v;
        endfunction

        function int unsigned rows_in_use();
            if (len_reg < 1) return 1;
            if (len_reg > STEPS) return STEPS;
            return len_reg;
        endfunction

        function longint add_sat(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return longint'(s);
        endfunction

        function longint mean_of(longint s, longint lo, longint hi);
            longint q;
            q = (traj_count == 0) ? s : s / longint'({32'd0, traj_count});
            if (q < lo) return lo;
            if (q > hi) return hi;
            return q;
        endfunction

        function void note_input(logic act, logic signed [23:0] px, logic signed [23:0] py,
                                 logic first);
            longint  dx, dy;
            t_result r;
            int unsigned n;
            n = rows_in_use();
            if (act == ACT_ADD) begin
                points_seen++;
                if (first) begin
                    org_x = px;
                    org_y = py;
                    cursor = 0;
                    if (traj_count != 32'hFFFF_FFFF) traj_count++;
                end
                if (cursor < n) begin
                    dx = longint'(px) - org_x;
                    dy = longint'(py) - org_y;
                    acc_x[cursor]  = add_sat(acc_x[cursor], dx);
                    acc_y[cursor]  = add_sat(acc_y[cursor], dy);
                    acc_x2[cursor] = add_sat(acc_x2[cursor], dx * dx);
                    acc_y2[cursor] = add_sat(acc_y2[cursor], dy * dy);
                    acc_xy[cursor] = add_sat(acc_xy[cursor], dx * dy);
                    cursor++;
                end
            end else begin
                fetches_seen++;
                for (int k = 0; k < n; k++) begin
                    r.step_index = 6'(k);
                    r.mean_x  = 25'(mean_of(acc_x[k], -longint'(M25), M25));
                    r.mean_y  = 25'(mean_of(acc_y[k], -longint'(M25), M25));
                    r.mean_x2 = 48'(mean_of(acc_x2[k], 0, M48));
                    r.mean_y2 = 48'(mean_of(acc_y2[k], 0, M48));
                    r.mean_xy = 49'(mean_of(acc_xy[k], -longint'(M48), M48));
                    r.last_entry = (k + 1 == n);
                    expected_words.push_back(r);
                end
                // a fetch with no trajectory counted leaves the table alone
                if (traj_count != 0) begin
                    for (int k = 0; k < STEPS; k++) begin
                        acc_x[k] = 0; acc_y[k] = 0; acc_x2[k] = 0;
                        acc_y2[k] = 0; acc_xy[k] = 0;
                    end
                    traj_count = 0;
                end
            end
        endfunction

        function void check_result(logic [207:0] data, logic last);
            t_result e;
            t_result a;
            bit      bad;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h last=%b", data, last);
                return;
            end
            e = expected_words.pop_front();
            a.step_index = data[5:0];
            a.mean_x     = data[30:6];
            a.mean_y     = data[55:31];
            a.mean_x2    = data[103:56];
            a.mean_y2    = data[151:104];
            a.mean_xy    = data[200:152];
            a.last_entry = last;
            words_checked++;
            bad = (a.step_index != e.step_index) || (a.mean_x != e.mean_x) ||
                  (a.mean_y != e.mean_y) || (a.mean_x2 != e.mean_x2) ||
                  (a.mean_y2 != e.mean_y2) || (a.mean_xy != e.mean_xy) ||
                  (a.last_entry != e.last_entry);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch step exp %0d got %0d, last exp %b got %b",
                             e.step_index, a.step_index, e.last_entry, a.last_entry);
                    $display("  x exp %h got %h, y exp %h got %h",
                             e.mean_x, a.mean_x, e.mean_y, a.mean_y);
                    $display("  x2 exp %h got %h, y2 exp %h got %h, xy exp %h got %h",
                             e.mean_x2, a.mean_x2, e.mean_y2, a.mean_y2,
                             e.mean_xy, a.mean_xy);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [6:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // pos_x[23:0], pos_y[47:24]
    logic [1:0]   s_axis_tuser;   // action[0], trajectory_start[1]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;   // step_index, mean_x, mean_y, mean_x2, mean_y2, mean_xy
    logic         m_axis_tlast;   // last_entry

    moment_scoreboard sb;
    int  burst_left;
    bit  pressure_req;
    int  idle_cycles = 0;

    displacement_moment_accumulator_core #(.MAX_STEPS(STEPS)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: check each accepted word, then pick the next ready level from a
    // pattern re-picked at random each phase; a pressure request holds it low long.
    initial begin
        int mode;
        int phase_cnt;
        int hold_cnt;
        bit hold_done;
        mode = 0;
        phase_cnt = 0;
        hold_cnt = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
            if (pressure_req && !hold_done) begin
                hold_cnt = HOLD_OFF;
                hold_done = 1'b1;
            end
            if (phase_cnt == 0) begin
                mode = $urandom_range(0, 3);
                phase_cnt = 64;
            end
            phase_cnt--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Offer one word; bursts of random length with random gaps between them.
    task automatic send_word(logic act, logic signed [23:0] px, logic signed [23:0] py,
                             logic first);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tuser  <= {first, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(act, px, py, first);
    endtask

    task automatic add_point(logic signed [23:0] px, logic signed [23:0] py, logic first);
        send_word(ACT_ADD, px, py, first);
    endtask

    task automatic fetch_table();
        send_word(ACT_FETCH, 24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid, wait for every predicted word, let the back end settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(logic [6:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_length(v);
    endtask

    function automatic logic signed [23:0] pick_pos(logic signed [23:0] centre);
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return centre + 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    initial begin
        int n;
        int items;
        logic signed [23:0] cx, cy;
        sb = new();
        sb.reset_state();
        sb.words_checked = 0;
        sb.points_seen = 0;
        sb.fetches_seen = 0;
        burst_left = 0;
        pressure_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Points before any start accumulate against a zero origin; the fetch
        // then has no count, so raw sums come out clamped and stay in the table.
        add_point(24'sh7FFFFF, 24'sh800000, 1'b0);
        add_point(24'sh7FFFFF, 24'sh800000, 1'b0);
        add_point(24'sh800000, 24'sh7FFFFF, 1'b0);
        fetch_table();
        fetch_table();
        drain();

        // Length zero acts as one row; points past the length are ignored.
        write_length(7'd0);
        add_point(24'sh000100, 24'shFFFF00, 1'b1);
        add_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        add_point(24'sh800000, 24'sh800000, 1'b1);
        add_point(24'sh000000, 24'sh000000, 1'b0);
        fetch_table();
        drain();

        // Length above the table size acts as the full table; widest displacements.
        write_length(7'd127);
        add_point(24'sh800000, 24'sh7FFFFF, 1'b1);
        add_point(24'sh7FFFFF, 24'sh800000, 1'b0);
        add_point(24'sh555555, 24'shAAAAAA, 1'b0);
        add_point(24'sh800000, 24'sh7FFFFF, 1'b1);
        add_point(24'shAAAAAA, 24'sh555555, 1'b0);
        fetch_table();
        drain();

        // Random trajectories: mostly short tables to keep the divider quick.
        items = 0;
        for (int ph = 0; items < 280; ph++) begin
            case (ph)
                0: write_length(7'd1);
                3: write_length(7'd64);
                default: write_length(7'($urandom_range(1, 8)));
            endcase
            n = sb.rows_in_use();
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) == 0) begin
                    add_point(24'($urandom), 24'($urandom), 1'b0);
                    items++;
                end
                cx = 24'($urandom);
                cy = 24'($urandom);
                add_point(cx, cy, 1'b1);
                items++;
                for (int k = 1; k < n + $urandom_range(0, 2) - ($urandom_range(0, 5) == 0);
                     k++) begin
                    add_point(pick_pos(cx), pick_pos(cy), 1'b0);
                    items++;
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                fetch_table();
                items++;
            end
            // Pressure: the receiver holds off while points keep coming behind
            // a fetch, so the back end waits on its output and the queue fills.
            if (ph == 2) begin
                pressure_req = 1'b1;
                fetch_table();
                items++;
                repeat (6) begin
                    add_point(pick_pos(cx), pick_pos(cy), 1'b0);
                    items++;
                end
            end
            fetch_table();
            items++;
            drain();
        end

        $display("covered %0d points and %0d fetches, %0d table words checked",
                 sb.points_seen, sb.fetches_seen, sb.words_checked);
        $display("lengths 0, 1, 64, 127 and random short tables, with long receiver stall");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/dma_pkg.sv
rtl/core/dma_queue.sv
rtl/core/dma_div.sv
rtl/core/dma_engine.sv
rtl/core/displacement_moment_accumulator_core.sv
tb/tb.sv
